@@ hw/rtl/hbs_pkg.sv @@
`default_nettype none
package hbs_pkg;

  localparam int unsigned MaxDim     = 1024;
  localparam int unsigned MapWords   = 1048576;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned FracBits   = 16;

  // action and result kind share one coding
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_LOAD  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH  = 3'd0,
    REG_MAP_HEIGHT = 3'd1,
    REG_ORIGIN_X   = 3'd2,
    REG_ORIGIN_Z   = 3'd3,
    REG_X_SCALE    = 3'd4,
    REG_Z_SCALE    = 3'd5,
    REG_ELEV_MIN   = 3'd6,
    REG_ELEV_STEP  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [10:0]        map_width;
    logic [10:0]        map_height;
    logic signed [25:0] origin_x;
    logic signed [25:0] origin_z;
    logic [31:0]        x_scale;
    logic [31:0]        z_scale;
    logic signed [23:0] elev_min;
    logic [31:0]        elev_step;
  } cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/hbs_cfg.sv @@
`default_nettype none
module hbs_cfg (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [4:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output hbs_pkg::cfg_t     cfg_o
);

  hbs_pkg::cfg_t    cfg_q;
  hbs_pkg::reg_idx_e idx;
  logic             wr;

  assign idx    = hbs_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q           <= '0;
      cfg_q.map_width <= 11'd1;
      cfg_q.map_height <= 11'd1;
    end else if (wr) begin
      case (idx)
        hbs_pkg::REG_MAP_WIDTH:  cfg_q.map_width  <= pwdata[10:0];
        hbs_pkg::REG_MAP_HEIGHT: cfg_q.map_height <= pwdata[10:0];
        hbs_pkg::REG_ORIGIN_X:   cfg_q.origin_x   <= pwdata[25:0];
        hbs_pkg::REG_ORIGIN_Z:   cfg_q.origin_z   <= pwdata[25:0];
        hbs_pkg::REG_X_SCALE:    cfg_q.x_scale    <= pwdata;
        hbs_pkg::REG_Z_SCALE:    cfg_q.z_scale    <= pwdata;
        hbs_pkg::REG_ELEV_MIN:   cfg_q.elev_min   <= pwdata[23:0];
        hbs_pkg::REG_ELEV_STEP:  cfg_q.elev_step  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hbs_pkg::REG_MAP_WIDTH:  prdata = {21'd0, cfg_q.map_width};
      hbs_pkg::REG_MAP_HEIGHT: prdata = {21'd0, cfg_q.map_height};
      hbs_pkg::REG_ORIGIN_X:   prdata = {{6{cfg_q.origin_x[25]}}, cfg_q.origin_x};
      hbs_pkg::REG_ORIGIN_Z:   prdata = {{6{cfg_q.origin_z[25]}}, cfg_q.origin_z};
      hbs_pkg::REG_X_SCALE:    prdata = cfg_q.x_scale;
      hbs_pkg::REG_Z_SCALE:    prdata = cfg_q.z_scale;
      hbs_pkg::REG_ELEV_MIN:   prdata = {{8{cfg_q.elev_min[23]}}, cfg_q.elev_min};
      hbs_pkg::REG_ELEV_STEP:  prdata = cfg_q.elev_step;
      default:                 prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/hbs_texel.sv @@
`default_nettype none
module hbs_texel #(
  parameter int unsigned MAX_DIM   = hbs_pkg::MaxDim,
  parameter int unsigned FRAC_BITS = hbs_pkg::FracBits,
  localparam int unsigned IdxW     = $clog2(MAX_DIM),
  localparam int unsigned DimW     = $clog2(MAX_DIM + 1)
) (
  input  wire                     clk_i,
  input  wire  signed [25:0]      coord_i,
  input  wire  signed [25:0]      origin_i,
  input  wire         [31:0]      scale_i,
  input  wire                     flip_i,
  input  wire         [DimW-1:0]  dim_i,
  output logic        [IdxW-1:0]  lo_o,
  output logic        [IdxW-1:0]  hi_o,
  output logic   [FRAC_BITS-1:0]  frac_o
);

  logic signed [26:0] delta_d, delta_q;
  logic signed [60:0] v_d, v_q;
  logic signed [29:0] q_s, q1_s, top_s;
  logic [IdxW-1:0]    lo_d, hi_d;

  // stage 1: offset from origin
  always_comb begin
    if (flip_i) begin
      delta_d = 27'(origin_i) - 27'(coord_i);
    end else begin
      delta_d = 27'(coord_i) - 27'(origin_i);
    end
  end

  // stage 2: scale to texels, half-texel shift
  assign v_d = $signed(delta_q) * $signed({1'b0, scale_i}) - 61'sh0_8000_0000;

  // stage 3: floor, clamp both neighbours
  always_comb begin
    q_s   = {v_q[60], v_q[60:32]};
    q1_s  = q_s + 30'sd1;
    top_s = $signed({{(30 - DimW){1'b0}}, dim_i}) - 30'sd1;
    if (q_s < 0) begin
      lo_d = '0;
    end else if (q_s > top_s) begin
      lo_d = top_s[IdxW-1:0];
    end else begin
      lo_d = q_s[IdxW-1:0];
    end
    if (q1_s < 0) begin
      hi_d = '0;
    end else if (q1_s > top_s) begin
      hi_d = top_s[IdxW-1:0];
    end else begin
      hi_d = q1_s[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    v_q     <= v_d;
    lo_o    <= lo_d;
    hi_o    <= hi_d;
    frac_o  <= v_q[31 -: FRAC_BITS];
  end

endmodule
`default_nettype wire

@@ hw/rtl/hbs_mem.sv @@
`default_nettype none
module hbs_mem #(
  parameter int unsigned DEPTH = hbs_pkg::MapWords,
  parameter int unsigned DW    = hbs_pkg::SampleBits,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire  [AW-1:0]           waddr_i,
  input  wire  [DW-1:0]           wdata_i,
  input  wire  [3:0][AW-1:0]      raddr_i,
  output wire  [3:0][DW-1:0]      rdata_o
);

  // one copy per neighbour, all written together
  for (genvar g = 0; g < 4; g++) begin : g_copy
    logic [DW-1:0] mem_q [DEPTH];
    logic [DW-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (we_i) begin
        mem_q[waddr_i] <= wdata_i;
      end
      rd_q <= mem_q[raddr_i[g]];
    end
    assign rdata_o[g] = rd_q;
  end

endmodule
`default_nettype wire

@@ hw/rtl/heightfield_bilinear_sampler.sv @@
`default_nettype none
// Heightfield bilinear sampler. Takes one command word per clock (busy is never
// raised) and answers each write, query and load with exactly one result word,
// strobed on done_o; an action code of 3 gives no result. Results arrive in
// command order and cannot be held off. A query maps world X/Z into texel space with
// the configured origins and scales, clamps the four neighbours to the map edges,
// interpolates and decodes to Q16.8 metres with saturation; before a load command it
// answers zero. The heightfield lives in four copies of one synchronous RAM, one copy
// per neighbour, so a query reads all four samples in the same cycle; sample writes go
// down the same pipeline and hit the RAM in the same stage as query reads, so every
// query sees exactly the writes issued before it. Configure only while idle.
module heightfield_bilinear_sampler #(
  parameter int unsigned MAX_DIM     = hbs_pkg::MaxDim,
  parameter int unsigned MAP_WORDS   = hbs_pkg::MapWords,
  parameter int unsigned SAMPLE_BITS = hbs_pkg::SampleBits,
  parameter int unsigned FRAC_BITS   = hbs_pkg::FracBits
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         action_i,
  input  wire  [19:0]        sample_index_i,
  input  wire  [15:0]        sample_value_i,
  input  wire  signed [25:0] world_x_i,
  input  wire  signed [25:0] world_z_i,
  output logic               done_o,
  output logic [1:0]         result_kind_o,
  output logic signed [23:0] elevation_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [4:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned IdxW = $clog2(MAX_DIM);
  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned MemW = $clog2(MAP_WORDS);
  localparam int unsigned RowW = IdxW + DimW;
  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned FB   = FRAC_BITS;
  localparam int unsigned AccW = SB + FB + 1;        // one-axis blend
  localparam int unsigned RW   = SB + 2 * FB + 2;    // two-axis blend
  localparam int unsigned RLo  = RW / 2;
  localparam int unsigned RHi  = RW - RLo;
  localparam int unsigned SH   = 2 * FB + 16;        // decode shift
  localparam int unsigned SW   = RW + 33;
  localparam int unsigned Depth = 10;                 // side-band pipe length

  hbs_pkg::cfg_t cfg;

  hbs_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  // never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // effective dimensions: zero acts as one, capped at the maximum
  logic [DimW-1:0] w_dim, h_dim;
  always_comb begin
    if (cfg.map_width == 11'd0) begin
      w_dim = DimW'(1);
    end else if (32'(cfg.map_width) > MAX_DIM) begin
      w_dim = DimW'(MAX_DIM);
    end else begin
      w_dim = DimW'(cfg.map_width);
    end
    if (cfg.map_height == 11'd0) begin
      h_dim = DimW'(1);
    end else if (32'(cfg.map_height) > MAX_DIM) begin
      h_dim = DimW'(MAX_DIM);
    end else begin
      h_dim = DimW'(cfg.map_height);
    end
  end

  // map loaded flag, snapshotted into each query at acceptance
  logic loaded_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else if (accept && action_i == hbs_pkg::ACT_LOAD) begin
      loaded_q <= 1'b1;
    end
  end

  // side band: valid, kind, loaded travel with the word to the output
  logic [Depth-1:0] vld_q;
  logic [1:0]       kind_q   [Depth];
  logic             ldd_q    [Depth-1];
  logic             vld_in;
  assign vld_in = accept && (action_i == hbs_pkg::ACT_WRITE ||
                             action_i == hbs_pkg::ACT_QUERY ||
                             action_i == hbs_pkg::ACT_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], vld_in};
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q[0] <= action_i;
    ldd_q[0]  <= loaded_q;
    for (int i = 1; i < Depth; i++) begin
      kind_q[i] <= kind_q[i-1];
    end
    for (int i = 1; i < Depth - 1; i++) begin
      ldd_q[i]  <= ldd_q[i-1];
    end
  end

  // write payload rides along to the ram stage (stage 5)
  logic [31:0]   widx_q [4];
  logic [SB-1:0] wval_q [4];
  always_ff @(posedge clk_i) begin
    widx_q[0] <= 32'(sample_index_i);
    wval_q[0] <= sample_value_i[SB-1:0];
    for (int i = 1; i < 4; i++) begin
      widx_q[i] <= widx_q[i-1];
      wval_q[i] <= wval_q[i-1];
    end
  end

  // stages 1..3: texel coordinates per axis
  logic [IdxW-1:0] xa, xb, za, zb;
  logic [FB-1:0]   tx, tz;

  hbs_texel #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FB)) u_tex_x (
    .clk_i, .coord_i(world_x_i), .origin_i(cfg.origin_x), .scale_i(cfg.x_scale),
    .flip_i(1'b0), .dim_i(w_dim), .lo_o(xa), .hi_o(xb), .frac_o(tx)
  );

  hbs_texel #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FB)) u_tex_z (
    .clk_i, .coord_i(world_z_i), .origin_i(cfg.origin_z), .scale_i(cfg.z_scale),
    .flip_i(1'b1), .dim_i(h_dim), .lo_o(za), .hi_o(zb), .frac_o(tz)
  );

  // stage 4: row base addresses
  logic [RowW-1:0] rowa_q, rowb_q;
  logic [IdxW-1:0] xa_q, xb_q;
  logic [FB-1:0]   tx4_q, tz4_q;
  always_ff @(posedge clk_i) begin
    rowa_q <= RowW'(za) * RowW'(w_dim);
    rowb_q <= RowW'(zb) * RowW'(w_dim);
    xa_q   <= xa;
    xb_q   <= xb;
    tx4_q  <= tx;
    tz4_q  <= tz;
  end

  // ram access: four neighbour reads, or the in-order sample write
  logic [3:0][31:0]     nb_addr;
  logic [3:0][MemW-1:0] rd_addr;
  logic [3:0]           nb_ok;
  logic                 wr_en;
  always_comb begin
    nb_addr[0] = 32'(rowa_q) + 32'(xa_q);
    nb_addr[1] = 32'(rowa_q) + 32'(xb_q);
    nb_addr[2] = 32'(rowb_q) + 32'(xa_q);
    nb_addr[3] = 32'(rowb_q) + 32'(xb_q);
    for (int i = 0; i < 4; i++) begin
      nb_ok[i]   = nb_addr[i] < 32'(MAP_WORDS);
      rd_addr[i] = nb_addr[i][MemW-1:0];
    end
  end

  assign wr_en = vld_q[3] && kind_q[3] == hbs_pkg::ACT_WRITE &&
                 widx_q[3] < 32'(MAP_WORDS);

  logic [3:0][SB-1:0] rd_data;

  hbs_mem #(.DEPTH(MAP_WORDS), .DW(SB)) u_mem (
    .clk_i, .we_i(wr_en), .waddr_i(widx_q[3][MemW-1:0]), .wdata_i(wval_q[3]),
    .raddr_i(rd_addr), .rdata_o(rd_data)
  );

  // stage 5: samples arrive; out-of-range neighbours read as zero
  logic [3:0]    ok5_q;
  logic [FB-1:0] tx5_q, tz5_q;
  always_ff @(posedge clk_i) begin
    ok5_q <= nb_ok;
    tx5_q <= tx4_q;
    tz5_q <= tz4_q;
  end

  logic [3:0][SB-1:0] h;
  logic [FB:0]        omtx, omtz;
  logic [AccW-1:0]    a_d, b_d, a_q, b_q;
  logic [FB-1:0]      tz6_q;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h[i] = ok5_q[i] ? rd_data[i] : '0;
    end
    omtx = (FB + 1)'(1) << FB;
    omtx = omtx - (FB + 1)'(tx5_q);
    a_d  = AccW'(h[0]) * AccW'(omtx) + AccW'(h[1]) * AccW'(tx5_q);
    b_d  = AccW'(h[2]) * AccW'(omtx) + AccW'(h[3]) * AccW'(tx5_q);
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    tz6_q <= tz5_q;
  end

  // stage 7: blend along z
  logic [RW-1:0] r_q;
  always_comb begin
    omtz = (FB + 1)'(1) << FB;
    omtz = omtz - (FB + 1)'(tz6_q);
  end
  always_ff @(posedge clk_i) begin
    r_q <= RW'(a_q) * RW'(omtz) + RW'(b_q) * RW'(tz6_q);
  end

  // stage 8: level times step, split into two partial products
  logic [RLo+31:0] plo_q;
  logic [RHi+31:0] phi_q;
  always_ff @(posedge clk_i) begin
    plo_q <= (RLo + 32)'(r_q[RLo-1:0]) * (RLo + 32)'(cfg.elev_step);
    phi_q <= (RHi + 32)'(r_q[RW-1:RLo]) * (RHi + 32)'(cfg.elev_step);
  end

  // stage 9: round, shift to Q.8, cap at 2^32
  logic [SW-1:0] sum, mag;
  logic [32:0]   m_q;
  always_comb begin
    sum = (SW'(phi_q) << RLo) + SW'(plo_q) + (SW'(1) << (SH - 1));
    mag = sum >> SH;
  end
  always_ff @(posedge clk_i) begin
    if (mag > SW'(33'h1_0000_0000)) begin
      m_q <= 33'h1_0000_0000;
    end else begin
      m_q <= mag[32:0];
    end
  end

  // stage 10: add offset, saturate, select answer
  logic signed [34:0] e_s;
  logic signed [23:0] e_sat, elev_d;
  always_comb begin
    e_s = 35'(cfg.elev_min) + $signed({2'b00, m_q});
    if (e_s > 35'sd8388607) begin
      e_sat = 24'sh7F_FFFF;
    end else if (e_s < -35'sd8388608) begin
      e_sat = 24'sh80_0000;
    end else begin
      e_sat = e_s[23:0];
    end
    if (kind_q[Depth-2] == hbs_pkg::ACT_QUERY && ldd_q[Depth-2]) begin
      elev_d = e_sat;
    end else begin
      elev_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    elevation_o <= elev_d;
  end

  assign done_o        = vld_q[Depth-1];
  assign result_kind_o = kind_q[Depth-1];

endmodule
`default_nettype wire

@@ hw/rtl/hbs_chk.sv @@
`default_nettype none
module hbs_chk (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               start,
  input wire               busy,
  input wire [1:0]         action_i,
  input wire               done_o,
  input wire [1:0]         result_kind_o,
  input wire signed [23:0] elevation_o
);

  logic acc;
  assign acc = start && !busy;

  a_query_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && action_i == hbs_pkg::ACT_QUERY |->
      ##10 done_o && result_kind_o == hbs_pkg::ACT_QUERY)
    else $error("query not answered in order");

  a_write_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && action_i == hbs_pkg::ACT_WRITE |->
      ##10 done_o && result_kind_o == hbs_pkg::ACT_WRITE && elevation_o == 24'sd0)
    else $error("write not acknowledged");

  a_load_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && action_i == hbs_pkg::ACT_LOAD |->
      ##10 done_o && result_kind_o == hbs_pkg::ACT_LOAD && elevation_o == 24'sd0)
    else $error("load not acknowledged");

  a_unused_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && action_i != hbs_pkg::ACT_WRITE && action_i != hbs_pkg::ACT_QUERY &&
      action_i != hbs_pkg::ACT_LOAD |-> ##10 !done_o)
    else $error("unused action produced a word");

endmodule

bind heightfield_bilinear_sampler hbs_chk u_chk (
  .clk_i, .rst_ni, .start, .busy, .action_i, .done_o, .result_kind_o, .elevation_o
);
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 16;  // pipeline is ten deep, keep margin

  // one command word as the sender sees it
  typedef struct {
    hbs_pkg::action_e act;
    bit [19:0]        idx;
    bit [15:0]        val;
    bit signed [25:0] wx;
    bit signed [25:0] wz;
  } cmd_t;

  // one answer word the block owes us
  typedef struct {
    bit [1:0]  kind;
    bit [23:0] elev;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = '0;
  logic [19:0] sample_index_i = '0;
  logic [15:0] sample_value_i = '0;
  logic signed [25:0] world_x_i = '0;
  logic signed [25:0] world_z_i = '0;
  logic done_o;
  logic [1:0] result_kind_o;
  logic signed [23:0] elevation_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  heightfield_bilinear_sampler DUT (
    .clk_i, .rst_ni, .start, .busy, .action_i, .sample_index_i, .sample_value_i,
    .world_x_i, .world_z_i, .done_o, .result_kind_o, .elevation_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // shadow of the block: configuration, heightfield and load flag
  bit [10:0]        sh_width = 11'd1;
  bit [10:0]        sh_height = 11'd1;
  bit signed [25:0] sh_origin_x = '0;
  bit signed [25:0] sh_origin_z = '0;
  bit [31:0]        sh_x_scale = '0;
  bit [31:0]        sh_z_scale = '0;
  bit signed [23:0] sh_elev_min = '0;
  bit [31:0]        sh_elev_step = '0;
  bit [15:0]        heights [int];
  bit               loaded = 1'b0;

  cmd_t    pending_cmds[$];
  answer_t owed_answers[$];
  int      idle_pct = 0;
  int      errors = 0;
  int      n_cmds = 0;
  int      n_queries = 0;
  int      n_answers = 0;
  int      n_settings = 0;
  int      quiet_cycles = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int dim_eff(bit [10:0] d);
    if (d == 0) return 1;
    if (d > hbs_pkg::MaxDim) return hbs_pkg::MaxDim;
    return int'(d);
  endfunction

  // world offset Q.8 times scale Q.24 minus half a texel; floor, clamp, keep fraction
  function automatic void to_texel(input longint delta, input bit [31:0] scale,
                                   input int dim, output int ia, output int ib,
                                   output longint frac);
    longint v;
    longint q;
    v = delta * longint'({32'b0, scale}) - (64'sd1 <<< 31);
    q = v >>> 32;
    frac = (v & 64'hFFFF_FFFF) >> (32 - hbs_pkg::FracBits);
    ia = q < 0 ? 0 : (q > dim - 1 ? dim - 1 : int'(q));
    ib = q + 1 < 0 ? 0 : (q + 1 > dim - 1 ? dim - 1 : int'(q + 1));
  endfunction

  function automatic bit [15:0] height_at(int a);
    return heights.exists(a) ? heights[a] : 16'd0;
  endfunction

  function automatic bit [23:0] predict_elevation(bit signed [25:0] wx, bit signed [25:0] wz);
    int w;
    int h;
    int xa, xb, za, zb;
    longint tx, tz;
    longint one;
    bit [63:0] a, b, r;
    bit [127:0] p;
    bit [127:0] m;
    longint e;
    w = dim_eff(sh_width);
    h = dim_eff(sh_height);
    one = 64'd1 << hbs_pkg::FracBits;
    to_texel(longint'(wx) - longint'(sh_origin_x), sh_x_scale, w, xa, xb, tx);
    to_texel(longint'(sh_origin_z) - longint'(wz), sh_z_scale, h, za, zb, tz);
    a = height_at(za * w + xa) * (one - tx) + height_at(za * w + xb) * tx;
    b = height_at(zb * w + xa) * (one - tx) + height_at(zb * w + xb) * tx;
    r = a * (one - tz) + b * tz;
    // decode: round to nearest Q.8, halves up, cap at 2^32
    p = {64'b0, r} * {96'b0, sh_elev_step} + (128'd1 << 47);
    m = p >> 48;
    if (m > (128'd1 << 32)) m = 128'd1 << 32;
    e = longint'(sh_elev_min) + longint'(m[32:0]);
    if (e > 8388607) e = 8388607;
    if (e < -8388608) e = -8388608;
    return e[23:0];
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // queue one answer word at the tail
  task automatic owe(bit [1:0] k, bit [23:0] e);
    answer_t x;
    x.kind = k;
    x.elev = e;
    owed_answers.insert(owed_answers.size(), x);
  endtask

  // sender: present the head word at the falling edge unless idling this cycle
  always @(negedge clk_i) begin
    if (rst_ni && pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      action_i <= pending_cmds[0].act;
      sample_index_i <= pending_cmds[0].idx;
      sample_value_i <= pending_cmds[0].val;
      world_x_i <= pending_cmds[0].wx;
      world_z_i <= pending_cmds[0].wz;
    end else begin
      start <= 1'b0;
    end
  end

  // acceptance, prediction, result check and watchdog, all on the rising edge
  always @(posedge clk_i) begin
    answer_t exp_a;
    bit      got;
    got = 1'b0;
    if (rst_ni && start && !busy) begin
      got = 1'b1;
      void'(pending_cmds.pop_front());
      n_cmds++;
      case (action_i)
        hbs_pkg::ACT_WRITE: begin
          if (sample_index_i < hbs_pkg::MapWords)
            heights[int'(sample_index_i)] = sample_value_i;
          owe(hbs_pkg::ACT_WRITE, 24'd0);
        end
        hbs_pkg::ACT_QUERY: begin
          n_queries++;
          owe(hbs_pkg::ACT_QUERY,
              loaded ? predict_elevation(world_x_i, world_z_i) : 24'd0);
        end
        hbs_pkg::ACT_LOAD: begin
          loaded = 1'b1;
          owe(hbs_pkg::ACT_LOAD, 24'd0);
        end
        default: ;  // unused code, no answer
      endcase
    end
    if (rst_ni && done_o) begin
      got = 1'b1;
      n_answers++;
      if (owed_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d", result_kind_o));
      end else begin
        exp_a = owed_answers.pop_front();
        if (result_kind_o !== exp_a.kind)
          report_mismatch($sformatf("kind %0d, want %0d", result_kind_o, exp_a.kind));
        if (elevation_o !== exp_a.elev)
          report_mismatch($sformatf("elevation %h, want %h (kind %0d)",
                                    elevation_o, exp_a.elev, exp_a.kind));
      end
    end
    quiet_cycles = got ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no traffic for %0d cycles", WatchdogLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(hbs_pkg::reg_idx_e r, bit [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      hbs_pkg::REG_MAP_WIDTH:  sh_width = v[10:0];
      hbs_pkg::REG_MAP_HEIGHT: sh_height = v[10:0];
      hbs_pkg::REG_ORIGIN_X:   sh_origin_x = v[25:0];
      hbs_pkg::REG_ORIGIN_Z:   sh_origin_z = v[25:0];
      hbs_pkg::REG_X_SCALE:    sh_x_scale = v;
      hbs_pkg::REG_Z_SCALE:    sh_z_scale = v;
      hbs_pkg::REG_ELEV_MIN:   sh_elev_min = v[23:0];
      hbs_pkg::REG_ELEV_STEP:  sh_elev_step = v;
      default: ;
    endcase
  endtask

  task automatic configure(bit [10:0] w, bit [10:0] h, bit [25:0] ox, bit [25:0] oz,
                           bit [31:0] xs, bit [31:0] zs, bit [23:0] emin, bit [31:0] step);
    write_reg(hbs_pkg::REG_MAP_WIDTH, {21'b0, w});
    write_reg(hbs_pkg::REG_MAP_HEIGHT, {21'b0, h});
    write_reg(hbs_pkg::REG_ORIGIN_X, {6'b0, ox});
    write_reg(hbs_pkg::REG_ORIGIN_Z, {6'b0, oz});
    write_reg(hbs_pkg::REG_X_SCALE, xs);
    write_reg(hbs_pkg::REG_Z_SCALE, zs);
    write_reg(hbs_pkg::REG_ELEV_MIN, {8'b0, emin});
    write_reg(hbs_pkg::REG_ELEV_STEP, step);
    n_settings++;
  endtask

  task automatic push_cmd(hbs_pkg::action_e a, bit [19:0] i, bit [15:0] v,
                          bit [25:0] x, bit [25:0] z);
    cmd_t c;
    c.act = a;
    c.idx = i;
    c.val = v;
    c.wx = x;
    c.wz = z;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // query aimed around the map in use; now and then anywhere in the world
  task automatic push_query();
    int dw, dh, ox, oz;
    dw = dim_eff(sh_width);
    dh = dim_eff(sh_height);
    if ($urandom_range(7) == 0) begin
      push_cmd(hbs_pkg::ACT_QUERY, 20'($urandom), 16'($urandom), 26'($urandom),
               26'($urandom));
    end else begin
      ox = int'(sh_origin_x) + int'($urandom_range(1024 * dw + 512)) - 256 * dw - 256;
      oz = int'(sh_origin_z) - int'($urandom_range(1024 * dh + 512)) + 256 * dh + 256;
      push_cmd(hbs_pkg::ACT_QUERY, 20'($urandom), 16'($urandom), 26'(ox), 26'(oz));
    end
  endtask

  // well-formed traffic: mostly queries, some sample rewrites and loads, a little noise
  task automatic push_random(int n);
    int k;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(99);
      if (k < 68) push_query();
      else if (k < 88)  // rewrite within the first 1024 samples, or anywhere
        push_cmd(hbs_pkg::ACT_WRITE,
                 $urandom_range(1) ? 20'($urandom_range(1023)) : 20'($urandom),
                 16'($urandom), 26'($urandom), 26'($urandom));
      else if (k < 94) push_cmd(hbs_pkg::ACT_LOAD, 20'($urandom), 16'($urandom),
                                26'($urandom), 26'($urandom));
      else push_cmd(hbs_pkg::action_e'(2'd3), 20'($urandom), 16'($urandom),
                    26'($urandom), 26'($urandom));
    end
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && owed_answers.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    bit [10:0] w;
    bit [10:0] h;
    int phases;
    phases = 14;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 24;

    // before the load flag every query answers zero; noise code gives nothing
    push_cmd(hbs_pkg::ACT_QUERY, '0, '0, 26'h1FFFFFF, 26'h2000000);
    push_cmd(hbs_pkg::ACT_QUERY, 20'hFFFFF, 16'hFFFF, 26'h2000000, 26'h1FFFFFF);
    push_cmd(hbs_pkg::action_e'(2'd3), 20'hFFFFF, 16'hFFFF, 26'h3FFFFFF, 26'h3FFFFFF);
    push_cmd(hbs_pkg::ACT_WRITE, 20'hFFFFF, 16'hFFFF, '0, '0);
    push_cmd(hbs_pkg::ACT_WRITE, 20'h80000, 16'h0000, '0, '0);
    // fill every sample a map of up to 1024 texels can touch
    for (int i = 0; i < 1024; i++)
      push_cmd(hbs_pkg::ACT_WRITE, 20'(i),
               (i % 97 == 0) ? 16'hFFFF : ((i % 89 == 0) ? 16'h0 : 16'($urandom)),
               26'($urandom), 26'($urandom));
    push_cmd(hbs_pkg::ACT_LOAD, '0, '0, '0, '0);
    // reset settings: 1x1 map, zero scales and step
    push_cmd(hbs_pkg::ACT_QUERY, '0, '0, 26'h1FFFFFF, 26'h2000000);
    push_cmd(hbs_pkg::ACT_QUERY, '0, '0, '0, '0);
    drain();

    // extremes: widest row, max elevation base and step
    configure(11'd1024, 11'd1, 26'h2000000, 26'h1FFFFFF, 32'hFFFF_FFFF, 32'd0,
              24'h7FFFFF, 32'hFFFF_FFFF);
    push_cmd(hbs_pkg::ACT_QUERY, '0, '0, 26'h2000000, 26'h1FFFFFF);
    push_cmd(hbs_pkg::ACT_QUERY, '0, '0, 26'h1FFFFFF, 26'h2000000);
    push_random(20);
    drain();
    // zero width acts as one, oversize height acts as the maximum
    configure(11'd0, 11'd2047, 26'd0, 26'd0, 32'd0, 32'h0100_0000, 24'h800000, 32'd0);
    push_cmd(hbs_pkg::ACT_QUERY, '0, '0, 26'd0, 26'h2000000);
    push_cmd(hbs_pkg::ACT_QUERY, '0, '0, 26'd0, 26'h1FFFFFF);
    push_random(20);
    drain();
    // oversize width, one row, one metre per level from the bottom
    configure(11'd2047, 11'd1, 26'h3FFFF00, 26'd0, 32'h0100_0000, 32'h0100_0000,
              24'h800000, 32'h0100_0000);
    push_random(20);
    drain();

    for (int p = 0; p < phases; p++) begin
      idle_pct = p < phases / 3 ? 24 : (p < 2 * phases / 3 ? 66 : 0);
      w = $urandom_range(3) == 0 ? 11'($urandom_range(1)) : 11'($urandom_range(1, 32));
      h = 11'($urandom_range(1, 1024 / dim_eff(w) < 32 ? 1024 / dim_eff(w) : 32));
      configure(w, h,
                $urandom_range(1) ? 26'($urandom) : 26'($urandom_range(4096)),
                $urandom_range(1) ? 26'($urandom) : 26'($urandom_range(4096)),
                $urandom_range(2) ? 32'($urandom_range(1, 8)) << $urandom_range(20, 25)
                                  : 32'($urandom),
                $urandom_range(2) ? 32'($urandom_range(1, 8)) << $urandom_range(20, 25)
                                  : 32'($urandom),
                24'($urandom),
                $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(1 << 20)));
      push_random(30);
      drain();
    end

    $display("covered %0d words (%0d queries) over %0d register settings, %0d answers",
             n_cmds, n_queries, n_settings, n_answers);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
